FILE: rtl/core/gpfa_pkg.sv
// ----------------------------------------------------------------------------
// gpfa_pkg
// shared widths, register indexes, reset values, limits and sequencer codes
// for the pair force accumulator
// ----------------------------------------------------------------------------
package gpfa_pkg;

    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 192;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'd1;

    localparam logic [31:0] GRAV_CONST_RST   = 32'd1;
    localparam logic [31:0] MIN_DISTANCE_RST = 32'd32768;

    localparam logic [63:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;

    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 128;

    typedef logic [2:0] t_state;
    localparam t_state S_IDLE = 3'd0;
    localparam t_state S_MUL  = 3'd1;
    localparam t_state S_SQRT = 3'd2;
    localparam t_state S_CHK  = 3'd3;
    localparam t_state S_DIV  = 3'd4;
    localparam t_state S_DEND = 3'd5;
    localparam t_state S_TMUL = 3'd6;
    localparam t_state S_FIN  = 3'd7;

endpackage

FILE: rtl/core/gravity_pair_force_accumulator.sv
// ----------------------------------------------------------------------------
// gravity_pair_force_accumulator
// pairwise gravity force terms summed into three saturating Q32.32 sums
// sequence per pair: multiply steps, square root, distance check, magnitude
// divide, then for each component a multiply, divide and accumulate, finish;
// a pair at zero or below the minimum distance goes from check to finish
// input: no new beat is taken until the current pair is finished, nor while
// a last beat's result waits; square root and divider share one subtractor
// reset: synchronous active low, sums cleared, registers at reset values
// ----------------------------------------------------------------------------
module gravity_pair_force_accumulator #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gpfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // target_x, target_y, target_z, target_mass, source_x, source_y,
    // source_z, source_mass
    input  logic [gpfa_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // first
    input  logic                            s_axis_tuser,
    // last
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // force_x, force_y, force_z
    output logic [gpfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                            m_axis_tuser
);
    import gpfa_pkg::*;

    localparam int PSH = (2 * POS_FRAC_BITS >= 32) ? 2 * POS_FRAC_BITS - 32 : 0;
    localparam int DSH = (2 * POS_FRAC_BITS < 32) ? 32 - 2 * POS_FRAC_BITS : 0;

    t_state         r_state;
    logic [2:0]     r_mstep;
    logic [7:0]     r_cnt;
    logic           r_mag_phase;
    logic [1:0]     r_axis;
    logic           r_last;
    logic [31:0]    r_grav;
    logic [31:0]    r_mind;
    logic [31:0]    r_tm;
    logic [31:0]    r_sm;
    logic [32:0]    r_ad [3];
    logic           r_neg [3];
    logic [63:0]    r_sum [3];
    logic           r_sat;
    logic [65:0]    r_dsq;
    logic [63:0]    r_t;
    logic [95:0]    r_p;
    logic [95:0]    r_acc;
    logic [62:0]    r_mag;
    logic [33:0]    r_dist;
    logic [127:0]   r_num;
    logic [127:0]   r_den;
    logic [127:0]   r_rem;
    logic [127:0]   r_quo;
    logic           r_ovalid;
    logic [191:0]   r_odata;
    logic           r_osat;

    logic [32:0]    mul_a;
    logic [32:0]    mul_b;
    logic [65:0]    prod;
    logic [128:0]   op_a;
    logic [128:0]   op_b;
    logic [129:0]   diff;
    logic           ge;
    logic [32:0]    dx;
    logic [32:0]    dy;
    logic [32:0]    dz;
    logic [63:0]    term;
    logic [63:0]    sum_in;
    logic [63:0]    sum_add;
    logic           sum_ovf;
    logic           in_beat;
    logic           out_load;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
    assign out_load = (r_state == S_FIN) && r_last && (!r_ovalid || m_axis_tready);

    assign dx = {s_axis_tdata[159], s_axis_tdata[159:128]} - {s_axis_tdata[31], s_axis_tdata[31:0]};
    assign dy = {s_axis_tdata[191], s_axis_tdata[191:160]} - {s_axis_tdata[63], s_axis_tdata[63:32]};
    assign dz = {s_axis_tdata[223], s_axis_tdata[223:192]} - {s_axis_tdata[95], s_axis_tdata[95:64]};

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            unique case (r_mstep)
                3'd0: begin mul_a = r_ad[0]; mul_b = r_ad[0]; end
                3'd1: begin mul_a = r_ad[1]; mul_b = r_ad[1]; end
                3'd2: begin mul_a = r_ad[2]; mul_b = r_ad[2]; end
                3'd3: begin mul_a = {1'b0, r_grav}; mul_b = {1'b0, r_tm}; end
                3'd4: begin mul_a = {1'b0, r_t[31:0]}; mul_b = {1'b0, r_sm}; end
                default: begin mul_a = {1'b0, r_t[63:32]}; mul_b = {1'b0, r_sm}; end
            endcase
        end else begin
            mul_b = r_ad[r_axis];
            if (r_mstep == 3'd0) begin
                mul_a = {1'b0, r_mag[31:0]};
            end else begin
                mul_a = {2'b0, r_mag[62:32]};
            end
        end
    end
    assign prod = mul_a * mul_b;

    // shared compare and subtract
    always_comb begin
        if (r_state == S_SQRT) begin
            op_a = {r_rem[126:0], r_num[127:126]};
            op_b = {r_quo[126:0], 2'b01};
        end else begin
            op_a = {r_rem, r_num[127]};
            op_b = {1'b0, r_den};
        end
    end
    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign ge   = !diff[129];

    assign term    = r_neg[r_axis] ? (64'd0 - r_quo[63:0]) : r_quo[63:0];
    assign sum_in  = r_sum[r_axis];
    assign sum_add = sum_in + term;
    assign sum_ovf = (sum_in[63] == term[63]) && (sum_add[63] != sum_in[63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_grav   <= GRAV_CONST_RST;
            r_mind   <= MIN_DISTANCE_RST;
            r_sat    <= 1'b0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_mstep  <= '0;
            r_cnt    <= '0;
            r_axis   <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GRAV_CONST:   r_grav <= i_cfg_data;
                    REG_MIN_DISTANCE: r_mind <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_tm     <= s_axis_tdata[127:96];
                        r_sm     <= s_axis_tdata[255:224];
                        r_neg[0] <= dx[32];
                        r_neg[1] <= dy[32];
                        r_neg[2] <= dz[32];
                        r_ad[0]  <= dx[32] ? 33'd0 - dx : dx;
                        r_ad[1]  <= dy[32] ? 33'd0 - dy : dy;
                        r_ad[2]  <= dz[32] ? 33'd0 - dz : dz;
                        r_last   <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_sum[0] <= '0;
                            r_sum[1] <= '0;
                            r_sum[2] <= '0;
                            r_sat    <= 1'b0;
                        end
                        r_mstep <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_mstep)
                        3'd0:    r_dsq <= prod;
                        3'd1,
                        3'd2:    r_dsq <= r_dsq + prod;
                        3'd3:    r_t   <= prod[63:0];
                        3'd4:    r_p   <= {32'd0, prod[63:0]};
                        default: r_p   <= r_p + {prod[63:0], 32'd0};
                    endcase
                    if (r_mstep == 3'd5) begin
                        r_num   <= {2'b0, r_dsq, 60'd0};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 8'(SQRT_STEPS);
                        r_state <= S_SQRT;
                    end else begin
                        r_mstep <= r_mstep + 3'd1;
                    end
                end
                S_SQRT: begin
                    r_rem <= ge ? diff[127:0] : op_a[127:0];
                    r_quo <= {r_quo[126:0], ge};
                    r_num <= {r_num[125:0], 2'b00};
                    r_cnt <= r_cnt - 8'd1;
                    if (r_cnt == 8'd1) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_dist <= r_quo[33:0];
                    if (r_dsq == '0 || r_quo[33:0] < {2'b0, r_mind}) begin
                        r_state <= S_FIN;
                    end else begin
                        r_num       <= {32'd0, r_p} << PSH;
                        r_den       <= {62'd0, r_dsq} << DSH;
                        r_rem       <= '0;
                        r_quo       <= '0;
                        r_cnt       <= 8'(DIV_STEPS);
                        r_mag_phase <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? diff[127:0] : op_a[127:0];
                    r_quo <= {r_quo[126:0], ge};
                    r_num <= {r_num[126:0], 1'b0};
                    r_cnt <= r_cnt - 8'd1;
                    if (r_cnt == 8'd1) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    if (r_mag_phase) begin
                        if (r_quo[127:63] != '0) begin
                            r_mag <= SMAX64[62:0];
                            r_sat <= 1'b1;
                        end else begin
                            r_mag <= r_quo[62:0];
                        end
                        r_mag_phase <= 1'b0;
                        r_axis      <= '0;
                        r_mstep     <= '0;
                        r_state     <= S_TMUL;
                    end else begin
                        if (sum_ovf) begin
                            r_sum[r_axis] <= sum_in[63] ? SMIN64 : SMAX64;
                            r_sat         <= 1'b1;
                        end else begin
                            r_sum[r_axis] <= sum_add;
                        end
                        r_mstep <= '0;
                        if (r_axis == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_TMUL: begin
                    priority case (r_mstep)
                        3'd0: begin
                            r_acc   <= {30'd0, prod};
                            r_mstep <= 3'd1;
                        end
                        3'd1: begin
                            r_acc   <= r_acc + {prod[63:0], 32'd0};
                            r_mstep <= 3'd2;
                        end
                        default: begin
                            r_num   <= {32'd0, r_acc};
                            r_den   <= {94'd0, r_dist};
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_cnt   <= 8'(DIV_STEPS);
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (out_load) begin
                        r_odata  <= {r_sum[2], r_sum[1], r_sum[0]};
                        r_osat   <= r_sat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/gpfa_checker.sv
// ----------------------------------------------------------------------------
// gpfa_checker
// port level checks for the pair force accumulator, bound to the top level
// ----------------------------------------------------------------------------
module gpfa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [gpfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import gpfa_pkg::*;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after reset");

endmodule

bind gravity_pair_force_accumulator gpfa_checker u_gpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
